[rtl/line_pixel_rasterizer_assert.svh]
// Assertion macros shared by the rasterizer modules.
`ifndef LINE_PIXEL_RASTERIZER_ASSERT_SVH
`define LINE_PIXEL_RASTERIZER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rasterizer same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rasterizer next-cycle check failed");

`endif

[rtl/lpr_pkg.sv]
package lpr_pkg;

   localparam int SCREEN_WIDTH  = 384;
   localparam int SCREEN_HEIGHT = 216;

   localparam int X_W     = 9;
   localparam int Y_W     = 8;
   localparam int ADDR_W  = 17;
   localparam int COLOR_W = 16;
   localparam int ERR_W   = 11;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_STEP  = 1'b1
   } command_type;

   // Endpoints and colour of a start transaction.
   typedef struct packed {
      logic [X_W-1:0]     ax;
      logic [Y_W-1:0]     ay;
      logic [X_W-1:0]     bx;
      logic [Y_W-1:0]     by;
      logic [COLOR_W-1:0] colour;
   } line_cmd_type;

   // Walker state of one line.
   typedef struct packed {
      logic               y_major;
      logic [X_W-1:0]     cur_x;
      logic [Y_W-1:0]     cur_y;
      logic [X_W-1:0]     major_end;
      logic               minor_down;
      logic [X_W-1:0]     major_delta;
      logic [X_W-1:0]     minor_delta;
      logic [ERR_W-1:0]   error_term;
      logic [COLOR_W-1:0] colour;
   } line_state_type;

   typedef struct packed {
      logic [X_W-1:0]     x;
      logic [Y_W-1:0]     y;
      logic [ADDR_W-1:0]  addr;
      logic [COLOR_W-1:0] colour;
      logic               last;
   } pixel_type;

endpackage

[rtl/lpr_setup.sv]
module lpr_setup (
   input  lpr_pkg::line_cmd_type   cmd,
   output lpr_pkg::line_state_type setup
);

   logic [lpr_pkg::X_W:0]   dx;
   logic [lpr_pkg::Y_W:0]   dy;
   logic [lpr_pkg::X_W-1:0] adx;
   logic [lpr_pkg::X_W-1:0] ady;
   logic                    y_major;
   logic                    swap;
   logic [lpr_pkg::X_W-1:0] ax;
   logic [lpr_pkg::Y_W-1:0] ay;
   logic [lpr_pkg::X_W-1:0] bx;
   logic [lpr_pkg::Y_W-1:0] by;
   logic [lpr_pkg::X_W-1:0] major_d;
   logic [lpr_pkg::X_W-1:0] minor_d;

   assign dx  = {1'b0, cmd.bx} - {1'b0, cmd.ax};
   assign dy  = {1'b0, cmd.by} - {1'b0, cmd.ay};
   assign adx = dx[lpr_pkg::X_W] ? lpr_pkg::X_W'(-dx) : dx[lpr_pkg::X_W-1:0];
   assign ady = dy[lpr_pkg::Y_W] ? lpr_pkg::X_W'(-dy) : lpr_pkg::X_W'(dy);

   // ties go to the y axis
   assign y_major = !(ady < adx);
   assign swap    = y_major ? (cmd.ay > cmd.by) : (cmd.ax > cmd.bx);

   assign ax = swap ? cmd.bx : cmd.ax;
   assign ay = swap ? cmd.by : cmd.ay;
   assign bx = swap ? cmd.ax : cmd.bx;
   assign by = swap ? cmd.ay : cmd.by;

   assign major_d = y_major ? ady : adx;
   assign minor_d = y_major ? adx : ady;

   always_comb begin
      setup.y_major     = y_major;
      setup.cur_x       = ax;
      setup.cur_y       = ay;
      setup.major_end   = y_major ? lpr_pkg::X_W'(by) : bx;
      setup.minor_down  = y_major ? (bx < ax) : (by < ay);
      setup.major_delta = major_d;
      setup.minor_delta = minor_d;
      setup.error_term  = {1'b0, minor_d, 1'b0} - {2'b00, major_d};
      setup.colour      = cmd.colour;
   end

endmodule

[rtl/lpr_stepper.sv]
`include "line_pixel_rasterizer_assert.svh"

module lpr_stepper (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    step,
   input  lpr_pkg::line_state_type setup,
   output logic                    active,
   output lpr_pkg::pixel_type      pix
);

   lpr_pkg::line_state_type state_ff;
   lpr_pkg::line_state_type state_in;
   logic                    active_ff;
   logic                    active_in;
   logic [lpr_pkg::X_W-1:0] major_now;
   logic                    err_pos;

   assign major_now = state_ff.y_major ? lpr_pkg::X_W'(state_ff.cur_y) : state_ff.cur_x;
   assign err_pos   = !state_ff.error_term[lpr_pkg::ERR_W-1] && (state_ff.error_term != '0);

   assign active     = active_ff;
   assign pix.x      = state_ff.cur_x;
   assign pix.y      = state_ff.cur_y;
   assign pix.addr   = lpr_pkg::ADDR_W'(lpr_pkg::ADDR_W'(state_ff.cur_y)
                       * lpr_pkg::ADDR_W'(lpr_pkg::SCREEN_WIDTH))
                       + lpr_pkg::ADDR_W'(state_ff.cur_x);
   assign pix.colour = state_ff.colour;
   assign pix.last   = (major_now == state_ff.major_end);

   always_comb begin
      state_in  = state_ff;
      active_in = active_ff;
      if (start) begin
         state_in  = setup;
         active_in = 1'b1;
      end else if (step && active_ff) begin
         if (pix.last) begin
            active_in = 1'b0;
         end else begin
            if (err_pos) begin
               // move the minor axis one toward its end
               if (state_ff.y_major) begin
                  state_in.cur_x = state_ff.minor_down ? state_ff.cur_x - 1'b1
                                                       : state_ff.cur_x + 1'b1;
               end else begin
                  state_in.cur_y = state_ff.minor_down ? state_ff.cur_y - 1'b1
                                                       : state_ff.cur_y + 1'b1;
               end
               state_in.error_term = state_ff.error_term
                                   + {1'b0, state_ff.minor_delta, 1'b0}
                                   - {1'b0, state_ff.major_delta, 1'b0};
            end else begin
               state_in.error_term = state_ff.error_term + {1'b0, state_ff.minor_delta, 1'b0};
            end
            if (state_ff.y_major) begin
               state_in.cur_y = state_in.cur_y + 1'b1;
            end else begin
               state_in.cur_x = state_in.cur_x + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      state_ff <= state_in;
   end

   `LPR_ASSERT_NEXT(a_start_arms, clock, reset, start, active_ff)
   `LPR_ASSERT_NEXT(a_last_idles, clock, reset, step && active_ff && pix.last, !active_ff)
   `LPR_ASSERT_NEXT(a_idle_holds, clock, reset, !start && !active_ff, !active_ff)

endmodule

[rtl/line_pixel_rasterizer.sv]
// Bresenham line rasterizer, all octants, one pixel per step transaction.
// Request channel (req_*): req_command selects start (load both endpoints and
// the colour, no response) or step (emit the next pixel of the active line).
// A step with no active line is dropped without a response.
// Response channel (rsp_*): pixel column and row, framebuffer word address
// row * SCREEN_WIDTH + column, colour, and rsp_last on the line's final pixel.
// After the last pixel the block goes idle; a start while a line is active
// abandons that line.
// A step passes through the input register, then the response register; it
// waits in the input register while the response register holds a stalled
// pixel.
// Throughput: one transaction per cycle while req_stall is low; the line walker
// updates its position and error term in the same cycle it produces a pixel.
// When rsp_stall holds a pending pixel, the input register still takes one
// more transaction; a further step then stalls req_* until the pixel is taken.
// Start and idle step transactions never wait on the response side.
// Reset (synchronous) empties both registers and leaves no line active.
`include "line_pixel_rasterizer_assert.svh"

module line_pixel_rasterizer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic [lpr_pkg::X_W-1:0]       req_start_x,
   input  logic [lpr_pkg::Y_W-1:0]       req_start_y,
   input  logic [lpr_pkg::X_W-1:0]       req_end_x,
   input  logic [lpr_pkg::Y_W-1:0]       req_end_y,
   input  logic [lpr_pkg::COLOR_W-1:0]   req_colour,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lpr_pkg::X_W-1:0]       rsp_pixel_x,
   output logic [lpr_pkg::Y_W-1:0]       rsp_pixel_y,
   output logic [lpr_pkg::ADDR_W-1:0]    rsp_word_address,
   output logic [lpr_pkg::COLOR_W-1:0]   rsp_pixel_colour,
   output logic                          rsp_last
);

   logic                    in_valid_ff;
   logic                    in_valid_in;
   lpr_pkg::command_type    in_cmd_ff;
   lpr_pkg::line_cmd_type   in_line_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   lpr_pkg::pixel_type      rsp_pix_ff;
   lpr_pkg::line_state_type setup;
   lpr_pkg::pixel_type      pix;
   logic                    active;
   logic                    req_take;
   logic                    go;
   logic                    needs_rsp;
   logic                    rsp_free;
   logic                    pixel_fire;

   lpr_setup u_setup (
      .cmd   (in_line_ff),
      .setup (setup)
   );

   lpr_stepper u_stepper (
      .clock  (clock),
      .reset  (reset),
      .start  (go && (in_cmd_ff == lpr_pkg::CMD_START)),
      .step   (go && (in_cmd_ff == lpr_pkg::CMD_STEP)),
      .setup  (setup),
      .active (active),
      .pix    (pix)
   );

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign needs_rsp  = (in_cmd_ff == lpr_pkg::CMD_STEP) && active;
   assign go         = in_valid_ff && (!needs_rsp || rsp_free);
   assign pixel_fire = go && needs_rsp;

   assign req_stall    = in_valid_ff && !go;
   assign req_take     = req_valid && !req_stall;
   assign in_valid_in  = req_take || (in_valid_ff && !go);
   assign rsp_valid_in = pixel_fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_take) begin
         in_cmd_ff         <= lpr_pkg::command_type'(req_command);
         in_line_ff.ax     <= req_start_x;
         in_line_ff.ay     <= req_start_y;
         in_line_ff.bx     <= req_end_x;
         in_line_ff.by     <= req_end_y;
         in_line_ff.colour <= req_colour;
      end
      if (pixel_fire) begin
         rsp_pix_ff <= pix;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_x      = rsp_pix_ff.x;
   assign rsp_pixel_y      = rsp_pix_ff.y;
   assign rsp_word_address = rsp_pix_ff.addr;
   assign rsp_pixel_colour = rsp_pix_ff.colour;
   assign rsp_last         = rsp_pix_ff.last;

   `LPR_ASSERT_NOW(a_load_when_free, clock, reset, pixel_fire, !rsp_valid_ff || !rsp_stall)
   `LPR_ASSERT_NOW(a_stall_needs_item, clock, reset, req_stall, in_valid_ff && needs_rsp)
   `LPR_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid_ff && rsp_stall, rsp_valid_ff && $stable(rsp_pix_ff))

endmodule

[test/tb_line_pixel_rasterizer.sv]
module tb_line_pixel_rasterizer;

   localparam int NUM_DIRECTED = 23;
   localparam int RANDOM_ITEMS = 1050;
   localparam int IDLE_PERCENT = 23;
   localparam int HOLD_CYCLES  = 64;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      lpr_pkg::command_type  command;
      lpr_pkg::line_cmd_type line;
   } raster_req_type;

   typedef struct packed {
      lpr_pkg::command_type  command;
      lpr_pkg::line_cmd_type line;
      logic                  typed;
      lpr_pkg::pixel_type    pixel;
   } directed_row_type;

   localparam lpr_pkg::line_cmd_type NO_LINE  = '0;
   localparam lpr_pkg::pixel_type    NO_PIXEL = '0;

   // Pixels that can be read straight off the line are written out; the rest
   // come from the line walker below.
   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{lpr_pkg::CMD_STEP,  NO_LINE, 1'b0, NO_PIXEL},
      '{lpr_pkg::CMD_START, '{9'd5, 8'd7, 9'd5, 8'd7, 16'hABCD}, 1'b0, NO_PIXEL},
      '{lpr_pkg::CMD_STEP,  NO_LINE, 1'b1, '{9'd5, 8'd7, 17'd2693, 16'hABCD, 1'b1}},
      '{lpr_pkg::CMD_STEP,  NO_LINE, 1'b0, NO_PIXEL},
      '{lpr_pkg::CMD_START, '{9'd0, 8'd0, 9'd511, 8'd255, 16'hFFFF}, 1'b0, NO_PIXEL},
      '{lpr_pkg::CMD_STEP,  NO_LINE, 1'b1, '{9'd0, 8'd0, 17'd0, 16'hFFFF, 1'b0}},
      '{lpr_pkg::CMD_STEP,  NO_LINE, 1'b0, NO_PIXEL},
      '{lpr_pkg::CMD_STEP,  NO_LINE, 1'b0, NO_PIXEL},
      '{lpr_pkg::CMD_START, '{9'd511, 8'd255, 9'd511, 8'd0, 16'h0000}, 1'b0, NO_PIXEL},
      '{lpr_pkg::CMD_STEP,  NO_LINE, 1'b1, '{9'd511, 8'd0, 17'd511, 16'h0000, 1'b0}},
      '{lpr_pkg::CMD_START, '{9'd383, 8'd215, 9'd380, 8'd215, 16'h5555}, 1'b0, NO_PIXEL},
      '{lpr_pkg::CMD_STEP,  NO_LINE, 1'b1, '{9'd380, 8'd215, 17'd82940, 16'h5555, 1'b0}},
      '{lpr_pkg::CMD_STEP,  NO_LINE, 1'b0, NO_PIXEL},
      '{lpr_pkg::CMD_STEP,  NO_LINE, 1'b0, NO_PIXEL},
      '{lpr_pkg::CMD_STEP,  NO_LINE, 1'b0, NO_PIXEL},
      '{lpr_pkg::CMD_START, '{9'd10, 8'd10, 9'd13, 8'd7, 16'h0F0F}, 1'b0, NO_PIXEL},
      '{lpr_pkg::CMD_STEP,  NO_LINE, 1'b0, NO_PIXEL},
      '{lpr_pkg::CMD_STEP,  NO_LINE, 1'b0, NO_PIXEL},
      '{lpr_pkg::CMD_STEP,  NO_LINE, 1'b0, NO_PIXEL},
      '{lpr_pkg::CMD_STEP,  NO_LINE, 1'b0, NO_PIXEL},
      '{lpr_pkg::CMD_STEP,  NO_LINE, 1'b0, NO_PIXEL},
      '{lpr_pkg::CMD_START, '{9'd0, 8'd255, 9'd511, 8'd254, 16'h1234}, 1'b0, NO_PIXEL},
      '{lpr_pkg::CMD_STEP,  NO_LINE, 1'b1, '{9'd0, 8'd255, 17'd97920, 16'h1234, 1'b0}}
   };

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_command = 1'b0;
   logic [lpr_pkg::X_W-1:0]       req_start_x = '0;
   logic [lpr_pkg::Y_W-1:0]       req_start_y = '0;
   logic [lpr_pkg::X_W-1:0]       req_end_x = '0;
   logic [lpr_pkg::Y_W-1:0]       req_end_y = '0;
   logic [lpr_pkg::COLOR_W-1:0]   req_colour = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [lpr_pkg::X_W-1:0]       rsp_pixel_x;
   logic [lpr_pkg::Y_W-1:0]       rsp_pixel_y;
   logic [lpr_pkg::ADDR_W-1:0]    rsp_word_address;
   logic [lpr_pkg::COLOR_W-1:0]   rsp_pixel_colour;
   logic                          rsp_last;

   // Line walker state
   logic                          walk_active = 1'b0;
   logic                          walk_y_major = 1'b0;
   logic                          walk_minor_down = 1'b0;
   logic [lpr_pkg::X_W-1:0]       walk_x = '0;
   logic [lpr_pkg::Y_W-1:0]       walk_y = '0;
   logic [lpr_pkg::X_W-1:0]       walk_major_end = '0;
   logic [lpr_pkg::X_W-1:0]       walk_major_delta = '0;
   logic [lpr_pkg::X_W-1:0]       walk_minor_delta = '0;
   int                            walk_error = 0;
   logic [lpr_pkg::COLOR_W-1:0]   walk_colour = '0;

   lpr_pkg::pixel_type            expected_pixels [$];
   int                            error_count = 0;
   int                            useful_items = 0;
   int                            quiet_cycles = 0;
   logic                          steady = 1'b0;
   logic                          hold_off = 1'b0;

   line_pixel_rasterizer u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .req_colour       (req_colour),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_word_address (rsp_word_address),
      .rsp_pixel_colour (rsp_pixel_colour),
      .rsp_last         (rsp_last)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic int clip_coord(int v, int hi);
      return v < 0 ? 0 : (v > hi ? hi : v);
   endfunction

   function automatic lpr_pkg::line_cmd_type make_line(int ax, int ay, int bx, int by,
                                                       int colour);
      lpr_pkg::line_cmd_type l;
      l.ax     = lpr_pkg::X_W'(ax);
      l.ay     = lpr_pkg::Y_W'(ay);
      l.bx     = lpr_pkg::X_W'(bx);
      l.by     = lpr_pkg::Y_W'(by);
      l.colour = lpr_pkg::COLOR_W'(colour);
      return l;
   endfunction

   // Step payload is don't-care; randomize it anyway.
   function automatic raster_req_type step_request();
      raster_req_type r;
      r.command = lpr_pkg::CMD_STEP;
      r.line    = make_line($urandom_range(511), $urandom_range(255), $urandom_range(511),
                            $urandom_range(255), $urandom_range(65535));
      return r;
   endfunction

   function automatic int pixel_count(lpr_pkg::line_cmd_type l);
      int adx;
      int ady;
      adx = int'(l.bx) - int'(l.ax);
      ady = int'(l.by) - int'(l.ay);
      if (adx < 0) adx = -adx;
      if (ady < 0) ady = -ady;
      return (adx > ady ? adx : ady) + 1;
   endfunction

   task automatic rasterize_command(input raster_req_type r, output logic produced,
                                    output lpr_pkg::pixel_type px);
      int                      ax;
      int                      ay;
      int                      bx;
      int                      by;
      int                      adx;
      int                      ady;
      int                      swap;
      logic [lpr_pkg::X_W-1:0] major_now;
      produced = 1'b0;
      px = '0;
      if (r.command == lpr_pkg::CMD_START) begin
         ax  = int'(r.line.ax);
         ay  = int'(r.line.ay);
         bx  = int'(r.line.bx);
         by  = int'(r.line.by);
         adx = bx > ax ? bx - ax : ax - bx;
         ady = by > ay ? by - ay : ay - by;
         // ties go to the y axis
         walk_y_major = !(ady < adx);
         if (walk_y_major ? ay > by : ax > bx) begin
            swap = ax; ax = bx; bx = swap;
            swap = ay; ay = by; by = swap;
         end
         if (walk_y_major) begin
            walk_minor_down  = bx < ax;
            walk_major_end   = lpr_pkg::X_W'(by);
            walk_major_delta = lpr_pkg::X_W'(ady);
            walk_minor_delta = lpr_pkg::X_W'(adx);
            walk_error       = 2 * adx - ady;
         end else begin
            walk_minor_down  = by < ay;
            walk_major_end   = lpr_pkg::X_W'(bx);
            walk_major_delta = lpr_pkg::X_W'(adx);
            walk_minor_delta = lpr_pkg::X_W'(ady);
            walk_error       = 2 * ady - adx;
         end
         walk_x      = lpr_pkg::X_W'(ax);
         walk_y      = lpr_pkg::Y_W'(ay);
         walk_colour = r.line.colour;
         walk_active = 1'b1;
      end else if (walk_active) begin
         if (walk_y_major) major_now = lpr_pkg::X_W'(walk_y);
         else major_now = walk_x;
         produced  = 1'b1;
         px.x      = walk_x;
         px.y      = walk_y;
         px.addr   = lpr_pkg::ADDR_W'(int'(walk_y) * lpr_pkg::SCREEN_WIDTH + int'(walk_x));
         px.colour = walk_colour;
         px.last   = major_now == walk_major_end;
         if (px.last) begin
            walk_active = 1'b0;
         end else begin
            if (walk_error > 0) begin
               if (walk_y_major) walk_x = walk_minor_down ? walk_x - 1'b1 : walk_x + 1'b1;
               else walk_y = walk_minor_down ? walk_y - 1'b1 : walk_y + 1'b1;
               walk_error += 2 * (int'(walk_minor_delta) - int'(walk_major_delta));
            end else begin
               walk_error += 2 * int'(walk_minor_delta);
            end
            if (walk_y_major) walk_y = walk_y + 1'b1;
            else walk_x = walk_x + 1'b1;
         end
      end
   endtask

   task automatic send_request(input raster_req_type r, input logic typed,
                               input lpr_pkg::pixel_type typed_pixel);
      logic               produced;
      lpr_pkg::pixel_type px;
      @(negedge clock);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= r.command;
      req_start_x <= r.line.ax;
      req_start_y <= r.line.ay;
      req_end_x   <= r.line.bx;
      req_end_y   <= r.line.by;
      req_colour  <= r.line.colour;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      rasterize_command(r, produced, px);
      if (produced) expected_pixels.push_back(typed ? typed_pixel : px);
      if (produced || r.command == lpr_pkg::CMD_START) useful_items++;
   endtask

   task automatic send_line(input lpr_pkg::line_cmd_type line, input int steps);
      send_request('{lpr_pkg::CMD_START, line}, 1'b0, NO_PIXEL);
      repeat (steps) send_request(step_request(), 1'b0, NO_PIXEL);
   endtask

   task automatic drain_pixels();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off = 1'b0;
         end
         rsp_stall <= !steady && $urandom_range(99) < IDLE_PERCENT;
      end
   end

   always @(posedge clock) begin
      lpr_pkg::pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected pixel transaction: x %0d y %0d", rsp_pixel_x, rsp_pixel_y);
            error_count++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_pixel_x !== want.x) begin
               $error("pixel_x: expected %0d, got %0d", want.x, rsp_pixel_x);
               error_count++;
            end
            if (rsp_pixel_y !== want.y) begin
               $error("pixel_y: expected %0d, got %0d", want.y, rsp_pixel_y);
               error_count++;
            end
            if (rsp_word_address !== want.addr) begin
               $error("word_address: expected %0d, got %0d", want.addr, rsp_word_address);
               error_count++;
            end
            if (rsp_pixel_colour !== want.colour) begin
               $error("pixel_colour: expected %h, got %h", want.colour, rsp_pixel_colour);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // Watchdog: end the run if no transaction moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("line_pixel_rasterizer test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      lpr_pkg::line_cmd_type line;
      int                    pick;
      int                    ax;
      int                    ay;
      int                    bx;
      int                    by;
      logic                  paused;
      logic                  held;
      paused = 1'b0;
      held   = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request('{directed_rows[i].command, directed_rows[i].line},
                      directed_rows[i].typed, directed_rows[i].pixel);

      useful_items = 0;
      while (useful_items < RANDOM_ITEMS) begin
         if (!paused && useful_items >= 300) begin
            paused = 1'b1;
            drain_pixels();
         end
         // Hold the result side while a long line keeps the input busy.
         if (!held && useful_items >= 500) begin
            held     = 1'b1;
            hold_off = 1'b1;
            line = make_line(20, 30, 140, 70, $urandom_range(65535));
            send_line(line, pixel_count(line));
         end
         steady = useful_items >= 650 && useful_items < 850;

         pick = $urandom_range(99);
         ax   = $urandom_range(511);
         ay   = $urandom_range(255);
         if (pick < 2) begin
            bx = $urandom_range(511);
            by = $urandom_range(255);
         end else begin
            bx = clip_coord(ax + int'($urandom_range(24)) - 12, 511);
            by = clip_coord(ay + int'($urandom_range(24)) - 12, 255);
         end
         line = make_line(ax, ay, bx, by, $urandom_range(65535));
         if (pick < 75) begin
            send_line(line, pixel_count(line));
         end else if (pick < 88) begin
            // abandon the line early with a fresh start
            send_line(line, $urandom_range(pixel_count(line) - 1));
         end else if (pick < 94) begin
            repeat ($urandom_range(3, 1)) send_request(step_request(), 1'b0, NO_PIXEL);
         end else begin
            send_request('{lpr_pkg::command_type'($urandom_range(1)), line}, 1'b0, NO_PIXEL);
         end
      end
      steady = 1'b0;

      drain_pixels();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("line_pixel_rasterizer test passed");
      end else begin
         $display("line_pixel_rasterizer test failed");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/lpr_pkg.sv
rtl/lpr_setup.sv
rtl/lpr_stepper.sv
rtl/line_pixel_rasterizer.sv
test/tb_line_pixel_rasterizer.sv
